// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the histogram equalizer rtl
// depends on nothing; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("implication failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("next-cycle check failed");

`endif

// ----- rtl/core/he_pkg.sv -----
// types, constants and codes of the histogram equalizer
// depends on nothing; imported by every module of the block but he_ram
`timescale 1ns / 1ps

package he_pkg;

  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned LEVELS     = 256;
  localparam int unsigned PIX_W      = $clog2(LEVELS);
  localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int unsigned PROD_W     = CNT_W + PIX_W;
  localparam int unsigned STEP_W     = $clog2(PIX_W);
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] mapped;
    logic             frame_end;
  } result_t;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_COUNT_LAST,
    OP_MAP,
    OP_MAP_LAST
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] pixel;
  } q_entry_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] numer;
    logic [CNT_W-1:0]  denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CNT,
    BK_MAP,
    BK_BLD_RD,
    BK_BLD_ACC,
    BK_BLD_DIV,
    BK_BLD_WAIT
  } back_state_t;

endpackage

// ----- rtl/core/he_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module he_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/he_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on he_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module he_div (
  input  logic             clk,
  input  logic             rst,
  input  he_pkg::div_req_t req,
  output he_pkg::div_rsp_t rsp
);

  import he_pkg::*;

  logic [PROD_W-1:0] rem;
  logic [CNT_W-1:0]  dsr;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [PROD_W-1:0] shifted;
  logic              ge;
  logic              done;
  logic [PIX_W-1:0]  quot;

  // quotient is known to fit in PIX_W bits, so start at the top bit
  assign shifted = PROD_W'(dsr) << step;
  assign ge      = rem >= shifted;
  assign rsp     = '{done: done, quot: quot};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.numer;
      dsr  <= req.denom;
      step <= STEP_W'(PIX_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - shifted;
      end
      quot <= {quot[PIX_W-2:0], ge};
      step <= step - 1'b1;
    end
  end

  `ASSERT_IMPLIES(a_no_restart, clk, rst, req.start, !busy)
  `ASSERT_NEXT(a_done_ends_busy, clk, rst, done, !busy || $past(req.start))
  `ASSERT_ALWAYS(a_done_idle, clk, rst, !(done && busy && !$past(req.start)), "done while busy")

endmodule

// ----- rtl/core/he_front.sv -----
// front end: accepts pixel transactions, classifies them and queues them
// depends on he_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module he_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  he_pkg::in_item_t item,
  output logic             q_valid,
  output he_pkg::q_entry_t q_head,
  input  logic             q_pop
);

  import he_pkg::*;

  q_entry_t          q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              push;
  q_entry_t          entry;

  always_comb begin
    entry.pixel = item.pixel;
    if (item.cmd == CMD_MAP) begin
      entry.op = item.last ? OP_MAP_LAST : OP_MAP;
    end else begin
      entry.op = item.last ? OP_COUNT_LAST : OP_COUNT;
    end
  end

  assign item_stall = cnt == QCNT_W'(QDEPTH);
  assign push       = item_valid && !item_stall;
  assign q_valid    = cnt != '0;
  assign q_head     = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        cnt <= cnt + 1'b1;
      end else if (q_pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry;
    end
  end

  `ASSERT_ALWAYS(a_q_bound, clk, rst, cnt <= QCNT_W'(QDEPTH), "queue overfilled")
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst, q_pop, cnt != '0)

endmodule

// ----- rtl/core/he_back.sv -----
// back end: histogram update, map build and map lookup with result register
// depends on he_pkg, he_ram, he_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module he_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  he_pkg::q_entry_t q_head,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_stall,
  output he_pkg::result_t  result
);

  import he_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  op_t               cur_op;
  logic [PIX_W-1:0]  cur_pix;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  cum;
  logic [PIX_W-1:0]  bld_idx;
  logic [LEVELS-1:0] bin_valid;
  logic              bin_vld_q;
  logic              map_built;

  logic              bin_we;
  logic [PIX_W-1:0]  bin_waddr;
  logic [CNT_W-1:0]  bin_wdata;
  logic              bin_re;
  logic [PIX_W-1:0]  bin_raddr;
  logic [CNT_W-1:0]  bin_rdata;
  logic [CNT_W-1:0]  bin_cur;

  logic              map_we;
  logic [PIX_W-1:0]  map_wdata;
  logic              map_re;
  logic [PIX_W-1:0]  map_rdata;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              under_bound;
  logic              res_free;
  logic              res_load;
  logic              clear;

  he_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .re    (bin_re),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  he_ram #(.WIDTH(PIX_W), .DEPTH(LEVELS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (bld_idx),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (q_head.pixel),
    .rdata (map_rdata)
  );

  he_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // bins never written since the last clear read as zero
  assign bin_cur     = bin_vld_q ? bin_rdata : '0;
  assign bin_waddr   = cur_pix;
  assign bin_wdata   = CNT_W'(bin_cur + 1'b1);
  assign under_bound = total < CNT_W'(MAX_PIXELS);
  assign res_free    = !result_valid || !result_stall;
  assign clear       = res_load && cur_op == OP_MAP_LAST;
  assign map_wdata   = (total == '0) ? '0 : div_rsp.quot;

  // numerator is cum * 255, done as a shift and subtract
  assign div_req.numer = (PROD_W'(cum) << PIX_W) - PROD_W'(cum);
  assign div_req.denom = total;

  always_comb begin
    state_next    = state;
    q_pop         = 1'b0;
    bin_re        = 1'b0;
    bin_raddr     = q_head.pixel;
    bin_we        = 1'b0;
    map_re        = 1'b0;
    map_we        = 1'b0;
    div_req.start = 1'b0;
    res_load      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.op == OP_COUNT || q_head.op == OP_COUNT_LAST) begin
            bin_re     = 1'b1;
            state_next = BK_CNT;
          end else begin
            map_re     = 1'b1;
            state_next = BK_MAP;
          end
        end
      end
      BK_CNT: begin
        bin_we     = under_bound;
        state_next = (cur_op == OP_COUNT_LAST) ? BK_BLD_RD : BK_IDLE;
      end
      BK_MAP: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      BK_BLD_RD: begin
        bin_re     = 1'b1;
        bin_raddr  = bld_idx;
        state_next = BK_BLD_ACC;
      end
      BK_BLD_ACC: begin
        state_next = BK_BLD_DIV;
      end
      BK_BLD_DIV: begin
        div_req.start = 1'b1;
        state_next    = BK_BLD_WAIT;
      end
      BK_BLD_WAIT: begin
        if (div_rsp.done) begin
          map_we     = 1'b1;
          state_next = (bld_idx == PIX_W'(LEVELS - 1)) ? BK_IDLE : BK_BLD_RD;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      total        <= '0;
      bin_valid    <= '0;
      map_built    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (bin_we) begin
        total              <= total + 1'b1;
        bin_valid[bin_waddr] <= 1'b1;
      end
      if (clear) begin
        total     <= '0;
        bin_valid <= '0;
      end
      if (map_we) begin
        map_built <= 1'b1;
      end
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_op  <= q_head.op;
      cur_pix <= q_head.pixel;
    end
    if (bin_re) begin
      bin_vld_q <= bin_valid[bin_raddr];
    end
    if (state == BK_CNT) begin
      cum     <= '0;
      bld_idx <= '0;
    end
    if (state == BK_BLD_ACC) begin
      cum <= CNT_W'(cum + bin_cur);
    end
    if (map_we) begin
      bld_idx <= bld_idx + 1'b1;
    end
    if (res_load) begin
      result.mapped    <= map_built ? map_rdata : '0;
      result.frame_end <= cur_op == OP_MAP_LAST;
    end
  end

  `ASSERT_ALWAYS(a_total_bound, clk, rst, total <= CNT_W'(MAX_PIXELS), "pixel total past bound")
  `ASSERT_NEXT(a_total_tracks_bin, clk, rst, bin_we, total == CNT_W'($past(total) + 1'b1))
  `ASSERT_NEXT(a_clear_empties, clk, rst, clear, total == '0 && bin_valid == '0)
  `ASSERT_NEXT(a_build_marks_map, clk, rst, map_we, map_built)

endmodule

// ----- rtl/core/histogram_equalizer.sv -----
// count or map item: popped in BK_IDLE and handled in BK_CNT or BK_MAP; none is popped outside BK_IDLE
// a map result is read into the map ram register, then loaded into the result register from BK_MAP once free
// a last count item adds a map build that walks every level through BK_BLD_RD, BK_BLD_ACC,
// BK_BLD_DIV and BK_BLD_WAIT; a 4-entry queue keeps accepting items meanwhile until it is full
// sync reset clears control state; histogram and map read as zero through
// per-bin valid bits and a map-built flag, so no clearing pass runs
`timescale 1ns / 1ps

module histogram_equalizer (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  he_pkg::in_item_t item,
  output logic             result_valid,
  input  logic             result_stall,
  output he_pkg::result_t  result
);

  import he_pkg::*;

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;

  he_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  he_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
